// File: hw/rtl/rcws_pkg.sv
`timescale 1ns / 1ps

package rcws_pkg;

	localparam int TILE               = 64;
	localparam int TILE_W             = $clog2(TILE);
	localparam int NUM_TEXTURES       = 4;
	localparam int TEXELS_PER_TEXTURE = 4096;
	localparam int MAX_COLUMNS        = 2048;
	localparam int ID_W               = $clog2(NUM_TEXTURES);
	localparam int IDX_W              = $clog2(TEXELS_PER_TEXTURE);
	localparam int ADDR_W             = ID_W + IDX_W;
	localparam int STORE_DEPTH        = NUM_TEXTURES * TEXELS_PER_TEXTURE;

	localparam int WALL_W = 24;
	localparam int NUM_W  = WALL_W + TILE_W + 8;
	localparam logic [WALL_W-1:0] WALL_MAX = {WALL_W{1'b1}};

	localparam logic [16:0] COS_C4  = 17'd60;
	localparam logic [16:0] COS_C3  = 17'd1367;
	localparam logic [16:0] COS_C2  = 17'd16625;
	localparam logic [16:0] COS_C1  = 17'd80852;
	localparam logic [17:0] COS_ONE = 18'd65536;

	localparam int Y_STEPS  = 7;
	localparam int ST_X2    = 2;
	localparam int ST_P3    = 3;
	localparam int ST_P2    = 4;
	localparam int ST_P1    = 5;
	localparam int ST_COS   = 6;
	localparam int ST_CD    = 7;
	localparam int ST_DIVIN = 8;
	localparam int ST_DIV0  = 9;
	localparam int ST_SPAN  = ST_DIV0 + WALL_W;
	localparam int ST_N2    = ST_SPAN + 1;
	localparam int ST_Y0    = ST_N2 + 1;
	localparam int ST_ADDR  = ST_Y0 + Y_STEPS;
	localparam int ST_MEM   = ST_ADDR + 1;

	typedef enum logic [2:0] {
		REG_VIEW_ANGLE      = 3'd0,
		REG_PROJ_PLANE_DIST = 3'd1,
		REG_SCREEN_HEIGHT   = 3'd2,
		REG_FLOOR_COLOR     = 3'd3,
		REG_CEIL_COLOR      = 3'd4,
		REG_TEX_WIDTH       = 3'd5,
		REG_TEX_HEIGHT      = 3'd6
	} reg_idx_t;

	localparam logic [10:0] SCREEN_HEIGHT_RST = 11'd480;
	localparam logic [6:0]  TEX_SIZE_RST      = 7'd64;

	typedef struct packed {
		logic              load;
		logic [ID_W-1:0]   id;
		logic [IDX_W-1:0]  idx;
		logic [31:0]       rgba;
		logic [23:0]       rdist;
		logic [10:0]       col;
		logic [10:0]       row;
		logic [6:0]        ox;
		logic              below_mid;
		logic              neg;
		logic [16:0]       x;
		logic [16:0]       x2;
		logic [16:0]       p;
		logic              behind;
		logic [WALL_W-1:0] cd;
		logic              sat;
		logic [WALL_W-1:0] rem;
		logic [WALL_W-1:0] wq;
		logic              in_wall;
		logic              vzero;
		logic              vsat;
		logic [WALL_W:0]   dv;
		logic [WALL_W:0]   r2;
		logic [Y_STEPS-1:0] q2;
	} pipe_t;

	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       wdata;
	} mem_req_t;

endpackage

// File: hw/rtl/rcws_tex_store.sv
`timescale 1ns / 1ps

module rcws_tex_store
	import rcws_pkg::*;
(
	input  logic        clk,
	input  mem_req_t    req,
	output logic [31:0] rdata
);

	logic [31:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end
			rdata <= mem[req.addr];
		end
	end

endmodule

// File: hw/rtl/raycast_wall_column_texel_shader_unit.sv
`timescale 1ns / 1ps
// channel   handshake                 payload
// item      item_valid / item_stall   mode tex_sel texel_addr texel_rgba ray_distance
//                                     ray_angle hit_x hit_y hit_vertical column row
// result    res_valid / res_stall     out_column out_row pixel_color is_wall
// config    cfg_wr_en                 cfg_index cfg_data
//
// One beat per clock while res_stall does not hold the pipe.
// Depth is set by the 24-step wall height divider and the 7-step texel row divider.
// Load beats write the texture store in the memory stage, in order with shade reads.
// Stages advance independently: bubbles close up under res_stall.
// Reset clears valid bits and sets the config registers to defaults; stage data and the texture store are not cleared.

module raycast_wall_column_texel_shader_unit
	import rcws_pkg::*;
#(
	parameter int MAX_COLS = MAX_COLUMNS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        mode,
	input  logic [1:0]  tex_sel,
	input  logic [11:0] texel_addr,
	input  logic [31:0] texel_rgba,
	input  logic [23:0] ray_distance,
	input  logic [15:0] ray_angle,
	input  logic [15:0] hit_x,
	input  logic [15:0] hit_y,
	input  logic        hit_vertical,
	input  logic [10:0] column,
	input  logic [10:0] row,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [10:0] out_column,
	output logic [10:0] out_row,
	output logic [31:0] pixel_color,
	output logic        is_wall
);

	logic [15:0] view_q;
	logic [23:0] ppd_q;
	logic [10:0] sh_q;
	logic [31:0] floor_q;
	logic [31:0] ceil_q;
	logic [6:0]  tw_q;
	logic [6:0]  th_q;
	logic [6:0]  tw_eff;
	logic [6:0]  th_eff;

	pipe_t pipe_s [1:ST_MEM];
	pipe_t nxt    [1:ST_MEM];
	logic  vld_s  [1:ST_MEM];
	logic  adv    [1:ST_MEM];
	logic  adv_out;
	logic  item_keep;

	mem_req_t    mreq;
	logic [31:0] rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_q  <= '0;
			ppd_q   <= '0;
			sh_q    <= SCREEN_HEIGHT_RST;
			floor_q <= '0;
			ceil_q  <= '0;
			tw_q    <= TEX_SIZE_RST;
			th_q    <= TEX_SIZE_RST;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_VIEW_ANGLE:      view_q  <= cfg_data[15:0];
				REG_PROJ_PLANE_DIST: ppd_q   <= cfg_data[23:0];
				REG_SCREEN_HEIGHT:   sh_q    <= cfg_data[10:0];
				REG_FLOOR_COLOR:     floor_q <= cfg_data;
				REG_CEIL_COLOR:      ceil_q  <= cfg_data;
				REG_TEX_WIDTH:       tw_q    <= cfg_data[6:0];
				REG_TEX_HEIGHT:      th_q    <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign tw_eff = (tw_q == 7'd0) ? 7'd1 : tw_q;
	assign th_eff = (th_q == 7'd0) ? 7'd1 : th_q;

	// ready chain
	assign adv_out = !res_valid || !res_stall;
	assign adv[ST_MEM] = !vld_s[ST_MEM] || adv_out;
	for (genvar k = 1; k < ST_MEM; k++) begin : g_adv
		assign adv[k] = !vld_s[k] || adv[k+1];
	end
	assign item_stall = !adv[1];

	// entry: fold angle, texel column
	always_comb begin
		logic [15:0]       diff;
		logic [14:0]       rr;
		logic [15:0]       coord;
		logic [TILE_W-1:0] ox_t;
		logic              mirror;
		logic [6:0]        ox_e;
		nxt[1] = '0;
		diff   = view_q - ray_angle;
		rr     = diff[14] ? (15'd16384 - {1'b0, diff[13:0]}) : {1'b0, diff[13:0]};
		coord  = hit_vertical ? hit_y : hit_x;
		ox_t   = coord[TILE_W-1:0];
		mirror = hit_vertical ? (ray_angle > 16'd16384 && ray_angle < 16'd49152)
			: (ray_angle != 16'd0 && ray_angle < 16'd32768);
		if (mirror) begin
			ox_t = TILE_W'(TILE - 1) - ox_t;
		end
		ox_e = 7'(ox_t);
		nxt[1].load      = !mode;
		nxt[1].id        = tex_sel[ID_W-1:0];
		nxt[1].idx       = texel_addr[IDX_W-1:0];
		nxt[1].rgba      = texel_rgba;
		nxt[1].rdist     = ray_distance;
		nxt[1].col       = column;
		nxt[1].row       = row;
		nxt[1].ox        = (ox_e >= tw_eff) ? tw_eff - 7'd1 : ox_e;
		nxt[1].below_mid = row < {1'b0, sh_q[10:1]};
		nxt[1].neg       = diff[15] ^ diff[14];
		nxt[1].x         = {rr, 2'b00};
	end

	assign item_keep = (row < sh_q) && (13'(column) < 13'(MAX_COLS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[1] <= 1'b0;
		end else if (adv[1]) begin
			vld_s[1] <= item_valid && (!mode || item_keep);
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			pipe_s[1] <= nxt[1];
		end
	end

	// cosine polynomial
	always_comb begin
		logic [33:0] prod;
		nxt[ST_X2]    = pipe_s[ST_X2-1];
		prod          = 34'(pipe_s[ST_X2-1].x) * 34'(pipe_s[ST_X2-1].x);
		nxt[ST_X2].x2 = prod[32:16];
	end

	always_comb begin
		logic [33:0] prod;
		nxt[ST_P3]   = pipe_s[ST_P3-1];
		prod         = 34'(COS_C4) * 34'(pipe_s[ST_P3-1].x2);
		nxt[ST_P3].p = COS_C3 - prod[32:16];
	end

	always_comb begin
		logic [33:0] prod;
		nxt[ST_P2]   = pipe_s[ST_P2-1];
		prod         = 34'(pipe_s[ST_P2-1].p) * 34'(pipe_s[ST_P2-1].x2);
		nxt[ST_P2].p = COS_C2 - prod[32:16];
	end

	always_comb begin
		logic [33:0] prod;
		nxt[ST_P1]   = pipe_s[ST_P1-1];
		prod         = 34'(pipe_s[ST_P1-1].p) * 34'(pipe_s[ST_P1-1].x2);
		nxt[ST_P1].p = COS_C1 - prod[32:16];
	end

	always_comb begin
		logic [33:0] prod;
		logic [17:0] t;
		logic [16:0] res;
		nxt[ST_COS]        = pipe_s[ST_COS-1];
		prod               = 34'(pipe_s[ST_COS-1].p) * 34'(pipe_s[ST_COS-1].x2);
		t                  = prod[33:16];
		res                = (t >= COS_ONE) ? 17'd0 : 17'(COS_ONE - t);
		nxt[ST_COS].p      = res;
		nxt[ST_COS].behind = pipe_s[ST_COS-1].neg && (res != 17'd0);
	end

	// fisheye correction
	always_comb begin
		logic [40:0] prod;
		nxt[ST_CD]    = pipe_s[ST_CD-1];
		prod          = 41'(pipe_s[ST_CD-1].rdist) * 41'(pipe_s[ST_CD-1].p);
		nxt[ST_CD].cd = prod[39:16];
	end

	// wall height divider set-up
	always_comb begin
		logic [NUM_W-1:0]  num;
		logic [WALL_W-1:0] hi;
		nxt[ST_DIVIN]     = pipe_s[ST_DIVIN-1];
		num               = (NUM_W'(ppd_q) * NUM_W'(TILE)) << 8;
		hi                = WALL_W'(num[NUM_W-1:WALL_W]);
		nxt[ST_DIVIN].sat = (pipe_s[ST_DIVIN-1].cd == '0) || (hi >= pipe_s[ST_DIVIN-1].cd);
		nxt[ST_DIVIN].rem = hi;
		nxt[ST_DIVIN].wq  = num[WALL_W-1:0];
	end

	for (genvar g = 0; g < WALL_W; g++) begin : g_wdiv
		always_comb begin
			logic [WALL_W+1:0] trial;
			pipe_t             cur;
			cur   = pipe_s[ST_DIV0+g-1];
			trial = {1'b0, cur.rem, cur.wq[WALL_W-1]} - {2'b00, cur.cd};
			nxt[ST_DIV0+g] = cur;
			if (!trial[WALL_W+1]) begin
				nxt[ST_DIV0+g].rem = trial[WALL_W-1:0];
				nxt[ST_DIV0+g].wq  = {cur.wq[WALL_W-2:0], 1'b1};
			end else begin
				nxt[ST_DIV0+g].rem = {cur.rem[WALL_W-2:0], cur.wq[WALL_W-1]};
				nxt[ST_DIV0+g].wq  = {cur.wq[WALL_W-2:0], 1'b0};
			end
		end
	end

	// wall span and texel row numerator
	always_comb begin
		pipe_t             cur;
		logic [WALL_W-1:0] wall;
		logic [18:0]       mid512;
		logic [25:0]       t;
		logic [16:0]       top;
		logic [24:0]       sum;
		logic [15:0]       bot;
		logic [26:0]       v;
		cur    = pipe_s[ST_SPAN-1];
		wall   = cur.behind ? '0 : (cur.sat ? WALL_MAX : cur.wq);
		mid512 = {sh_q[10:1], 9'd0};
		t      = 26'(mid512) - 26'(wall);
		top    = (!t[25] && t != '0) ? t[25:9] : 17'd0;
		sum    = 25'(mid512) + 25'(wall);
		bot    = (sum[24:9] > 16'(sh_q)) ? 16'(sh_q) : sum[24:9];
		v      = 27'({cur.row, 9'd0}) + 27'(wall) - 27'(mid512);
		nxt[ST_SPAN]         = cur;
		nxt[ST_SPAN].in_wall = (17'(cur.row) >= top) && (16'(cur.row) < bot);
		nxt[ST_SPAN].vzero   = v[26] || (v == '0);
		nxt[ST_SPAN].r2      = v[WALL_W:0];
		nxt[ST_SPAN].dv      = {wall, 1'b0};
	end

	always_comb begin
		logic [31:0] n2;
		pipe_t       cur;
		cur              = pipe_s[ST_N2-1];
		n2               = 32'(cur.r2) * 32'(th_eff);
		nxt[ST_N2]       = cur;
		nxt[ST_N2].vsat  = cur.r2 >= cur.dv;
		nxt[ST_N2].r2    = n2[31:Y_STEPS];
		nxt[ST_N2].q2    = n2[Y_STEPS-1:0];
	end

	for (genvar g = 0; g < Y_STEPS; g++) begin : g_ydiv
		always_comb begin
			logic [WALL_W+2:0] trial;
			pipe_t             cur;
			cur   = pipe_s[ST_Y0+g-1];
			trial = {1'b0, cur.r2, cur.q2[Y_STEPS-1]} - {2'b00, cur.dv};
			nxt[ST_Y0+g] = cur;
			if (!trial[WALL_W+2]) begin
				nxt[ST_Y0+g].r2 = trial[WALL_W:0];
				nxt[ST_Y0+g].q2 = {cur.q2[Y_STEPS-2:0], 1'b1};
			end else begin
				nxt[ST_Y0+g].r2 = {cur.r2[WALL_W-1:0], cur.q2[Y_STEPS-1]};
				nxt[ST_Y0+g].q2 = {cur.q2[Y_STEPS-2:0], 1'b0};
			end
		end
	end

	// texel address
	always_comb begin
		pipe_t       cur;
		logic [6:0]  oy;
		logic [13:0] idxf;
		cur  = pipe_s[ST_ADDR-1];
		oy   = cur.vzero ? 7'd0 : (cur.vsat ? th_eff - 7'd1 : cur.q2);
		idxf = 14'(oy) * 14'(tw_eff) + 14'(cur.ox);
		nxt[ST_ADDR] = cur;
		if (!cur.load) begin
			nxt[ST_ADDR].idx = idxf[IDX_W-1:0];
		end
	end

	assign nxt[ST_MEM] = pipe_s[ST_MEM-1];

	for (genvar k = 2; k <= ST_MEM; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k]) begin
				pipe_s[k] <= nxt[k];
			end
		end
	end

	assign mreq.en    = adv[ST_MEM];
	assign mreq.we    = vld_s[ST_ADDR] && pipe_s[ST_ADDR].load;
	assign mreq.addr  = {pipe_s[ST_ADDR].id, pipe_s[ST_ADDR].idx};
	assign mreq.wdata = pipe_s[ST_ADDR].rgba;

	rcws_tex_store u_store (
		.clk   (clk),
		.req   (mreq),
		.rdata (rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv_out) begin
			res_valid <= vld_s[ST_MEM] && !pipe_s[ST_MEM].load;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out) begin
			out_column  <= pipe_s[ST_MEM].col;
			out_row     <= pipe_s[ST_MEM].row;
			is_wall     <= pipe_s[ST_MEM].in_wall;
			pixel_color <= pipe_s[ST_MEM].in_wall ? rdata
				: (pipe_s[ST_MEM].below_mid ? ceil_q : floor_q);
		end
	end

endmodule

// File: hw/rtl/rcws_checker.sv
`timescale 1ns / 1ps

module rcws_checker
	import rcws_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_wr_en,
	input logic [2:0]  cfg_index,
	input logic [31:0] cfg_data,
	input logic        item_valid,
	input logic        item_stall,
	input logic        res_valid,
	input logic        res_stall,
	input logic [10:0] out_column,
	input logic [10:0] out_row,
	input logic [31:0] pixel_color,
	input logic        is_wall
);

	logic [10:0] sh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_wr_en && cfg_index == REG_SCREEN_HEIGHT) begin
			sh_q <= cfg_data[10:0];
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(out_column) && $stable(out_row)
			&& $stable(pixel_color) && $stable(is_wall))
		else $error("stalled result beat changed");

	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid)
		else $error("stalled item beat dropped");

	a_stall_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> res_valid && res_stall)
		else $error("item stalled while result side free");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> out_row < sh_q)
		else $error("result row beyond screen height");

endmodule

bind raycast_wall_column_texel_shader_unit rcws_checker u_rcws_checker (.*);

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import rcws_pkg::*;

	typedef struct {
		bit        mode;
		bit [1:0]  tex_id;
		bit [11:0] taddr;
		bit [31:0] rgba;
		bit [23:0] rdist;
		bit [15:0] angle;
		bit [15:0] hx;
		bit [15:0] hy;
		bit        vert;
		bit [10:0] col;
		bit [10:0] row;
	} shade_item_t;

	typedef struct {
		bit [10:0] col;
		bit [10:0] row;
		bit [31:0] color;
		bit        wall;
	} pixel_t;

	typedef struct {
		shade_item_t it;
		bit          typed;
		bit          has;
		pixel_t      px;
	} dir_row_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_wr_en = 0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic        item_valid = 0;
	logic        item_stall;
	logic        mode = 0;
	logic [1:0]  tex_sel = '0;
	logic [11:0] texel_addr = '0;
	logic [31:0] texel_rgba = '0;
	logic [23:0] ray_distance = '0;
	logic [15:0] ray_angle = '0;
	logic [15:0] hit_x = '0;
	logic [15:0] hit_y = '0;
	logic        hit_vertical = 0;
	logic [10:0] column = '0;
	logic [10:0] row = '0;
	logic        res_valid;
	logic        res_stall = 0;
	logic [10:0] out_column;
	logic [10:0] out_row;
	logic [31:0] pixel_color;
	logic        is_wall;

	raycast_wall_column_texel_shader_unit dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	bit [15:0] m_view;
	bit [23:0] m_ppd;
	bit [10:0] m_height;
	bit [31:0] m_floor;
	bit [31:0] m_ceil;
	bit [6:0]  m_texw;
	bit [6:0]  m_texh;
	bit [31:0] tex_mem [STORE_DEPTH];
	bit        tex_written [STORE_DEPTH];

	pixel_t pixel_q[$];
	int     errors = 0;
	int     tx_idle = 24;
	int     rx_idle = 49;

	function automatic longint cos_quarter(longint r);
		longint x, x2, p, res;
		x = r << 2;
		x2 = (x * x) >>> 16;
		p = 60;
		p = 1367 - ((p * x2) >>> 16);
		p = 16625 - ((p * x2) >>> 16);
		p = 80852 - ((p * x2) >>> 16);
		res = 65536 - ((p * x2) >>> 16);
		return res < 0 ? 0 : res;
	endfunction

	function automatic longint cos_bam(bit [15:0] a);
		longint r;
		r = a[13:0];
		case (a[15:14])
			2'd0: return cos_quarter(r);
			2'd1: return -cos_quarter(16384 - r);
			2'd2: return -cos_quarter(r);
			default: return cos_quarter(16384 - r);
		endcase
	endfunction

	// returns 1 when the item yields a pixel; idx is the texel read, or -1
	function automatic bit shade_pixel(input shade_item_t it, output pixel_t px, output int idx);
		bit [15:0] d;
		longint c, cd, wall, mid, t, top, bot, v, q, tw, th, ox, oy;
		idx = -1;
		px = '{default: 0};
		if (!it.mode || it.row >= m_height)
			return 0;
		d = m_view - it.angle;
		c = cos_bam(d);
		if (c < 0) begin
			wall = 0;
		end else begin
			cd = (longint'(it.rdist) * c) >>> 16;
			if (cd == 0) begin
				wall = 'hFFFFFF;
			end else begin
				wall = ((64 * longint'(m_ppd)) << 8) / cd;
				if (wall > 'hFFFFFF) wall = 'hFFFFFF;
			end
		end
		mid = m_height >> 1;
		t = mid * 512 - wall;
		top = t <= 0 ? 0 : (t >>> 9);
		bot = (mid * 512 + wall) >>> 9;
		if (bot > m_height) bot = m_height;
		px.col = it.col;
		px.row = it.row;
		if (it.row >= top && it.row < bot) begin
			tw = m_texw ? m_texw : 1;
			th = m_texh ? m_texh : 1;
			v = longint'(it.row) * 512 + wall - mid * 512;
			if (v <= 0) begin
				oy = 0;
			end else begin
				q = (v * th) / (2 * wall);
				oy = q >= th ? th - 1 : q;
			end
			ox = (it.vert ? it.hy : it.hx) % 64;
			if ((it.vert && it.angle > 16384 && it.angle < 49152) ||
				(!it.vert && it.angle > 0 && it.angle < 32768))
				ox = 63 - ox;
			if (ox >= tw) ox = tw - 1;
			idx = it.tex_id * TEXELS_PER_TEXTURE + (oy * tw + ox) % TEXELS_PER_TEXTURE;
			px.color = tex_mem[idx];
			px.wall = 1;
		end else begin
			px.color = it.row < mid ? m_ceil : m_floor;
		end
		return 1;
	endfunction

	task automatic report(string what, longint want, longint got);
		$display("ERROR %0t: %s expected %0h got %0h", $realtime, what, want, got);
		errors++;
	endtask

	always @(posedge clk) begin
		pixel_t e;
		if (arst_n && res_valid && !res_stall) begin
			if (pixel_q.size() == 0) begin
				report("unexpected beat, column", 0, out_column);
			end else begin
				e = pixel_q.pop_front();
				if (out_column !== e.col) report("out_column", e.col, out_column);
				if (out_row !== e.row) report("out_row", e.row, out_row);
				if (pixel_color !== e.color) report("pixel_color", e.color, pixel_color);
				if (is_wall !== e.wall) report("is_wall", e.wall, is_wall);
			end
		end
		res_stall <= arst_n && ($urandom_range(99) < rx_idle);
	end

	task automatic drive_beat(input shade_item_t it);
		while ($urandom_range(99) < tx_idle) begin
			item_valid <= 0;
			@(posedge clk);
		end
		item_valid <= 1;
		mode <= it.mode;
		tex_sel <= it.tex_id;
		texel_addr <= it.taddr;
		texel_rgba <= it.rgba;
		ray_distance <= it.rdist;
		ray_angle <= it.angle;
		hit_x <= it.hx;
		hit_y <= it.hy;
		hit_vertical <= it.vert;
		column <= it.col;
		row <= it.row;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic load_texel(bit [1:0] id, bit [11:0] a, bit [31:0] rgba);
		shade_item_t it;
		it = '{default: 0};
		it.tex_id = id;
		it.taddr = a;
		it.rgba = rgba;
		drive_beat(it);
		tex_mem[id * TEXELS_PER_TEXTURE + a] = rgba;
		tex_written[id * TEXELS_PER_TEXTURE + a] = 1;
	endtask

	// fill the texel first if this pixel would read an unwritten one
	task automatic send_checked(input shade_item_t it);
		pixel_t px;
		int     idx;
		bit     has;
		if (!it.mode) begin
			load_texel(it.tex_id, it.taddr, it.rgba);
			return;
		end
		has = shade_pixel(it, px, idx);
		if (idx >= 0 && !tex_written[idx]) begin
			load_texel(2'(idx / TEXELS_PER_TEXTURE), 12'(idx % TEXELS_PER_TEXTURE), $urandom);
			has = shade_pixel(it, px, idx);
		end
		drive_beat(it);
		if (has) pixel_q.push_back(px);
	endtask

	task automatic drain;
		item_valid <= 0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t r, bit [31:0] v);
		cfg_wr_en <= 1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		case (r)
			REG_VIEW_ANGLE:      m_view = v[15:0];
			REG_PROJ_PLANE_DIST: m_ppd = v[23:0];
			REG_SCREEN_HEIGHT:   m_height = v[10:0];
			REG_FLOOR_COLOR:     m_floor = v;
			REG_CEIL_COLOR:      m_ceil = v;
			REG_TEX_WIDTH:       m_texw = v[6:0];
			default:             m_texh = v[6:0];
		endcase
	endtask

	task automatic configure(bit [15:0] va, bit [23:0] ppd, bit [10:0] h, bit [6:0] tw,
			bit [6:0] th);
		drain();
		write_reg(REG_VIEW_ANGLE, va);
		write_reg(REG_PROJ_PLANE_DIST, ppd);
		write_reg(REG_SCREEN_HEIGHT, h);
		write_reg(REG_FLOOR_COLOR, $urandom);
		write_reg(REG_CEIL_COLOR, $urandom);
		write_reg(REG_TEX_WIDTH, tw);
		write_reg(REG_TEX_HEIGHT, th);
		cfg_wr_en <= 0;
	endtask

	function automatic shade_item_t random_item();
		shade_item_t it;
		int          k;
		it.mode = $urandom_range(99) >= 15;
		it.tex_id = 2'($urandom);
		it.taddr = 12'($urandom);
		it.rgba = $urandom;
		k = $urandom_range(9);
		it.rdist = k < 7 ? 24'($urandom_range(1 << 20, 4096)) :
			(k < 9 ? 24'($urandom) : 24'($urandom_range(255)));
		it.angle = $urandom_range(4) == 0 ? 16'($urandom) :
			16'(m_view + $urandom_range(24000) - 12000);
		it.hx = 16'($urandom);
		it.hy = 16'($urandom);
		it.vert = 1'($urandom);
		it.col = 11'($urandom);
		it.row = $urandom_range(9) == 0 ? 11'($urandom) : 11'($urandom_range(m_height - 1));
		return it;
	endfunction

	dir_row_t dir_rows[] = '{
		'{'{0, 3, 12'hFFF, 32'hFFFFFFFF, 0, 0, 0, 0, 0, 0, 0}, 1, 0, '{0, 0, 0, 0}},
		'{'{0, 0, 12'h000, 32'h00000000, 0, 0, 0, 0, 0, 0, 0}, 1, 0, '{0, 0, 0, 0}},
		'{'{1, 0, 0, 0, 24'd1, 16'h0000, 0, 0, 0, 0, 0}, 1, 1, '{0, 0, 0, 0}},
		'{'{1, 3, 0, 0, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 2047, 479}, 1, 1,
			'{2047, 479, 0, 0}},
		'{'{1, 1, 0, 0, 24'd5000, 16'h8000, 0, 0, 0, 5, 239}, 1, 1, '{5, 239, 0, 0}},
		'{'{1, 1, 0, 0, 24'd5000, 16'h1234, 0, 0, 0, 6, 480}, 1, 0, '{0, 0, 0, 0}},
		'{'{1, 2, 0, 0, 24'd5000, 16'h1234, 0, 0, 1, 7, 2047}, 1, 0, '{0, 0, 0, 0}},
		'{'{1, 0, 0, 0, 24'd0, 16'h0000, 16'h0000, 16'h0000, 0, 1, 0}, 0, 0, '{0, 0, 0, 0}},
		'{'{1, 1, 0, 0, 24'd0, 16'h4001, 16'hFFFF, 16'h0000, 0, 2, 240}, 0, 0, '{0, 0, 0, 0}},
		'{'{1, 2, 0, 0, 24'd0, 16'h4001, 16'h0000, 16'hFFFF, 1, 3, 479}, 0, 0, '{0, 0, 0, 0}},
		'{'{1, 3, 0, 0, 24'd0, 16'hC000, 16'h0021, 16'h003F, 1, 4, 100}, 0, 0, '{0, 0, 0, 0}},
		'{'{1, 3, 0, 0, 24'd0, 16'h8000, 16'h0021, 16'h003F, 0, 4, 300}, 0, 0, '{0, 0, 0, 0}}
	};

	initial begin
		int n;
		m_height = SCREEN_HEIGHT_RST;
		m_texw = TEX_SIZE_RST;
		m_texh = TEX_SIZE_RST;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (dir_rows[i]) begin
			if (dir_rows[i].typed) begin
				drive_beat(dir_rows[i].it);
				if (!dir_rows[i].it.mode) begin
					tex_mem[dir_rows[i].it.tex_id * TEXELS_PER_TEXTURE + dir_rows[i].it.taddr] =
						dir_rows[i].it.rgba;
					tex_written[dir_rows[i].it.tex_id * TEXELS_PER_TEXTURE +
						dir_rows[i].it.taddr] = 1;
				end
				if (dir_rows[i].has) pixel_q.push_back(dir_rows[i].px);
			end else begin
				send_checked(dir_rows[i].it);
			end
		end
		n = 0;
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: configure(16'($urandom), 24'd200 << 8, 11'd480, 7'd64, 7'd64);
				1: configure(16'hFFFF, 24'hFFFFFF, 11'd2047, 7'd1, 7'd1);
				2: configure(16'($urandom), 24'd1, 11'd1, 7'd0, 7'd0);
				3: configure(16'h0000, 24'd100 << 8, 11'd481, 7'd127, 7'd127);
				default: configure(16'($urandom), 24'd30 << 8, 11'd7, 7'd13, 7'd40);
			endcase
			for (int i = 0; i < 270; i++, n++) begin
				if (n == 450) begin
					tx_idle = 49;
					rx_idle = 24;
				end else if (n == 900) begin
					tx_idle = 0;
					rx_idle = 0;
				end
				if (i == 135) drain();
				send_checked(random_item());
			end
		end
		drain();
		if (errors == 0 && pixel_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
